### rtl/two_link_arm_inverse_kinematics_core_macros.svh
// Assertion helpers for the top-level core file.
`ifndef TWO_LINK_ARM_INVERSE_KINEMATICS_CORE_MACROS_SVH
`define TWO_LINK_ARM_INVERSE_KINEMATICS_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TLIK_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("tlik assertion failed");

// Next-cycle implication, checked outside reset.
`define TLIK_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tlik assertion failed");

`endif

### rtl/tlik_pkg.sv
package tlik_pkg;

  // CORDIC depth, capped at the table length
  localparam int CORDIC_STAGES = 16;
  localparam int CORDIC_ITERS  = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;

  // geometry constants (1/8 mm and 1/64 mm^2 units)
  localparam logic signed [13:0] A_OFS   = 14'sd48;
  localparam logic signed [13:0] B_OFS   = 14'sd224;
  localparam logic [22:0]        R_LIN   = 23'd5098752;
  localparam logic signed [63:0] R_CONST = 64'sd46905163776;
  localparam logic signed [33:0] K1      = 34'sd2160;
  localparam logic signed [33:0] K2      = 34'sd2352;
  localparam logic signed [33:0] X_OFS   = 34'sd216576;

  // pulse constants
  localparam logic [11:0]        PULSE_MIN  = 12'd600;
  localparam logic [11:0]        PULSE_MAX  = 12'd2400;
  localparam logic [11:0]        ORIGIN_RST = 12'd1500;
  localparam logic signed [47:0] PULSE_GAIN = 48'sd7200;
  localparam logic signed [47:0] T_LO       = 48'sd2576980377600;
  localparam logic signed [47:0] T_HI       = 48'sd10307921510400;
  localparam logic signed [47:0] T_HALF     = 48'sd2147483648;

  // register indexes
  localparam logic REG_J1 = 1'b0;
  localparam logic REG_J2 = 1'b1;

  // one word between front and back
  typedef struct packed {
    logic signed [15:0] a8;
    logic signed [15:0] b8;
    logic [30:0]        r;
    logic               reach;
    logic [42:0]        dval;
  } tlik_item_t;

  typedef struct packed {
    logic push;
    logic full;
  } tlik_qin_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } tlik_qout_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SQRT, BK_PREP, BK_ROT, BK_CORD, BK_MUL, BK_FIN
  } bk_state_t;

  // atan(2^-i) as binary angle, full turn = 2^32
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### rtl/two_link_arm_inverse_kinematics_core.sv
// channel  | ports                                  | flow
// input    | in_valid/in_stall, in_target_*         | target word in
// result   | out_valid/out_stall, out_joint*, ...   | pulse word out
// config   | psel/penable/pwrite/paddr/pwdata/...   | origin pulses
// Flow: a word passes the front pipe registers into the queue; the back pass
// takes 22 root steps, then PREP, ROT, CORDIC_STAGES (16) rotations, MUL and
// FIN, after which out_valid rises; an unreachable target goes straight from
// IDLE to FIN. One word per back pass; a 4-word queue decouples.
// Reset (rst_n low, synchronous) empties pipe and queue, origins go to 1500.
// out_stall holds the result word; a full queue raises in_stall once a word waits to push.
`include "two_link_arm_inverse_kinematics_core_macros.svh"

module two_link_arm_inverse_kinematics_core import tlik_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [12:0] in_target_distance,
  input  logic signed [12:0] in_target_height,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_joint1_pulse,
  output logic [11:0]        out_joint2_pulse,
  output logic               out_reachable,
  output logic               out_joint1_clamped,
  output logic               out_joint2_clamped,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [11:0] origin1_r, origin2_r;
  logic        cfg_wr;
  tlik_qin_t   qin;
  tlik_qout_t  qout;
  tlik_item_t  f_word, b_word;
  logic        q_full, q_pop;

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin1_r <= ORIGIN_RST;
      origin2_r <= ORIGIN_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_J1:  origin1_r <= pwdata[11:0];
        REG_J2:  origin2_r <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_J2) ? {20'b0, origin2_r} : {20'b0, origin1_r};

  tlik_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_target_distance, .in_target_height,
    .qin, .q_full, .q_word(f_word)
  );

  tlik_queue u_queue (
    .clk, .rst_n, .qin, .wr_word(f_word), .pop(q_pop), .qout, .full(q_full),
    .rd_word(b_word)
  );

  tlik_back u_back (
    .clk, .rst_n, .qout, .q_word(b_word), .q_pop,
    .origin1(origin1_r), .origin2(origin2_r),
    .out_valid, .out_stall, .out_joint1_pulse, .out_joint2_pulse,
    .out_reachable, .out_joint1_clamped, .out_joint2_clamped
  );

  // checks
  `TLIK_ASSERT_IMP(a_j1_range, out_valid, (out_joint1_pulse >= PULSE_MIN) && (out_joint1_pulse <= PULSE_MAX))
  `TLIK_ASSERT_IMP(a_j2_range, out_valid, (out_joint2_pulse >= PULSE_MIN) && (out_joint2_pulse <= PULSE_MAX))
  `TLIK_ASSERT_IMP(a_unreach_flag, out_valid && !out_reachable && (origin1_r >= PULSE_MIN) && (origin1_r <= PULSE_MAX), !out_joint1_clamped && (out_joint1_pulse == origin1_r))
  `TLIK_ASSERT_NEXT(a_cfg_j1, cfg_wr && (paddr[2] == REG_J1), origin1_r == $past(pwdata[11:0]))

endmodule

### rtl/tlik_front.sv
module tlik_front import tlik_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [12:0] in_target_distance,
  input  logic signed [12:0] in_target_height,
  output tlik_qin_t          qin,
  input  logic               q_full,
  output tlik_item_t         q_word
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv;
  logic signed [15:0] a1_r, b1_r, a2_r, b2_r, a3_r, b3_r, a4_r, b4_r;
  logic signed [13:0] xm, ym;
  logic signed [16:0] a5, b5;
  logic signed [31:0] sqa, sqb;
  logic [29:0] sa2_r, sb2_r;
  logic [30:0] r3_r, r4_r;
  logic [61:0] rr4_r;
  logic [53:0] kr4_r;
  logic signed [63:0] d;

  // whole pipe freezes when the last stage cannot push
  assign in_stall = v4_r && q_full;
  assign adv      = !in_stall;

  // stage 1: offset and scale to 1/8 mm
  assign xm = 14'(in_target_distance) - A_OFS;
  assign ym = 14'(in_target_height) - B_OFS;
  assign a5 = (17'(xm) <<< 2) + 17'(xm);
  assign b5 = (17'(ym) <<< 2) + 17'(ym);

  // stage 2 squares
  assign sqa = 32'(a1_r) * 32'(a1_r);
  assign sqb = 32'(b1_r) * 32'(b1_r);

  // radicand, exact
  assign d = $signed(64'(kr4_r)) - $signed(64'(rr4_r)) - R_CONST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r  <= a5[15:0];
      b1_r  <= b5[15:0];
      a2_r  <= a1_r;
      b2_r  <= b1_r;
      sa2_r <= sqa[29:0];
      sb2_r <= sqb[29:0];
      a3_r  <= a2_r;
      b3_r  <= b2_r;
      r3_r  <= {1'b0, sa2_r} + {1'b0, sb2_r};
      a4_r  <= a3_r;
      b4_r  <= b3_r;
      r4_r  <= r3_r;
      rr4_r <= 62'(r3_r) * 62'(r3_r);
      kr4_r <= 54'(r3_r) * 54'(R_LIN);
    end
  end

  assign qin.push     = v4_r && !q_full;
  assign qin.full     = q_full;
  assign q_word.a8    = a4_r;
  assign q_word.b8    = b4_r;
  assign q_word.r     = r4_r;
  assign q_word.reach = !d[63];
  assign q_word.dval  = d[42:0];

endmodule

### rtl/tlik_queue.sv
module tlik_queue import tlik_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  tlik_qin_t  qin,
  input  tlik_item_t wr_word,
  input  logic       pop,
  output tlik_qout_t qout,
  output logic       full,
  output tlik_item_t rd_word
);

  tlik_item_t  mem_r [4];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  cnt_r;
  logic        do_pop;

  assign full       = (cnt_r == 3'd4);
  assign qout.empty = (cnt_r == 3'd0);
  assign do_pop     = pop && !qout.empty;
  assign qout.pop   = do_pop;
  assign rd_word    = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (qin.push) wp_r <= wp_r + 2'd1;
      if (do_pop)   rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(qin.push) - 3'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (qin.push) mem_r[wp_r] <= wr_word;
  end

endmodule

### rtl/tlik_back.sv
module tlik_back import tlik_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  tlik_qout_t  qout,
  input  tlik_item_t  q_word,
  output logic        q_pop,
  input  logic [11:0] origin1,
  input  logic [11:0] origin2,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_joint1_pulse,
  output logic [11:0] out_joint2_pulse,
  output logic        out_reachable,
  output logic        out_joint1_clamped,
  output logic        out_joint2_clamped
);

  bk_state_t st_r, st_nxt;
  logic      load_item, load_out, out_free;

  logic signed [15:0] a8_r, b8_r;
  logic [30:0] r_r;
  logic        reach_r;
  logic [42:0] rem_r, res_r, bit_r;
  logic [43:0] sum;
  logic [21:0] sq;
  logic signed [33:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [33:0] cx1_r, cy1_r, cx2_r, cy2_r;
  logic [31:0] z1_r, z2_r;
  logic        xn1_r, yp1_r, zv1_r, xn2_r, yp2_r, zv2_r;
  logic [4:0]  it_r;
  logic [31:0] at;
  logic signed [32:0] ang1, ang2;
  logic signed [47:0] p1_r, p2_r, t1, t2;
  logic [11:0] pl1, pl2;
  logic        f1, f2;
  logic        out_valid_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= BK_IDLE;
    else        st_r <= st_nxt;
  end

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (!qout.empty) st_nxt = q_word.reach ? BK_SQRT : BK_FIN;
      BK_SQRT: if (bit_r[0]) st_nxt = BK_PREP;
      BK_PREP: st_nxt = BK_ROT;
      BK_ROT:  st_nxt = BK_CORD;
      BK_CORD: if (it_r == 5'(CORDIC_ITERS - 1)) st_nxt = BK_MUL;
      BK_MUL:  st_nxt = BK_FIN;
      BK_FIN:  if (out_free) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    load_item = 1'b0;
    load_out  = 1'b0;
    case (st_r)
      BK_IDLE: load_item = !qout.empty;
      BK_FIN:  load_out  = out_free;
      default: ;
    endcase
  end
  assign q_pop = load_item;

  // square root step and rounding
  assign sum = {1'b0, res_r} + {1'b0, bit_r};
  assign sq  = res_r[21:0] + 22'(rem_r > res_r);

  // angle fixups after the CORDIC
  always_comb begin
    ang1 = {z1_r[31], z1_r};
    if (xn1_r && yp1_r && ang1 < 0)   ang1 = 33'sh080000000;
    if (xn1_r && !yp1_r && ang1 > 0)  ang1 = -33'sh080000000;
    if (zv1_r)                        ang1 = '0;
    ang2 = {z2_r[31], z2_r};
    if (xn2_r && yp2_r && ang2 < 0)   ang2 = 33'sh080000000;
    if (xn2_r && !yp2_r && ang2 > 0)  ang2 = -33'sh080000000;
    if (zv2_r)                        ang2 = '0;
  end

  assign at = atan_lut(it_r);

  // pulse from origin and angle product
  assign t1 = $signed({4'b0, origin1, 32'b0}) + p1_r;
  assign t2 = $signed({4'b0, origin2, 32'b0}) + p2_r;

  always_comb begin
    logic signed [47:0] tr1, tr2;
    tr1 = t1 + T_HALF;
    tr2 = t2 + T_HALF;
    if (!reach_r) begin
      f1  = (origin1 < PULSE_MIN) || (origin1 > PULSE_MAX);
      pl1 = (origin1 < PULSE_MIN) ? PULSE_MIN : (origin1 > PULSE_MAX) ? PULSE_MAX : origin1;
      f2  = (origin2 < PULSE_MIN) || (origin2 > PULSE_MAX);
      pl2 = (origin2 < PULSE_MIN) ? PULSE_MIN : (origin2 > PULSE_MAX) ? PULSE_MAX : origin2;
    end else begin
      f1  = (t1 < T_LO) || (t1 > T_HI);
      pl1 = (t1 < T_LO) ? PULSE_MIN : (t1 > T_HI) ? PULSE_MAX : tr1[43:32];
      f2  = (t2 < T_LO) || (t2 > T_HI);
      pl2 = (t2 < T_LO) ? PULSE_MIN : (t2 > T_HI) ? PULSE_MAX : tr2[43:32];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      BK_IDLE: begin
        if (load_item) begin
          a8_r    <= q_word.a8;
          b8_r    <= q_word.b8;
          r_r     <= q_word.r;
          reach_r <= q_word.reach;
          rem_r   <= q_word.dval;
          res_r   <= '0;
          bit_r   <= 43'h400_0000_0000;
        end
      end
      BK_SQRT: begin
        if ({1'b0, rem_r} >= sum) begin
          rem_r <= rem_r - sum[42:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      BK_PREP: begin
        x1_r <= $signed({3'b0, r_r}) + 34'(b8_r) * K1 - X_OFS;
        y1_r <= 34'(a8_r) * K1 - $signed({12'b0, sq});
        x2_r <= $signed({3'b0, r_r}) + 34'(a8_r) * K2 + X_OFS;
        y2_r <= 34'(b8_r) * K2 - $signed({12'b0, sq});
      end
      BK_ROT: begin
        xn1_r <= x1_r < 0;
        yp1_r <= y1_r >= 0;
        zv1_r <= (x1_r == 0) && (y1_r == 0);
        cx1_r <= (x1_r < 0) ? -x1_r : x1_r;
        cy1_r <= (x1_r < 0) ? -y1_r : y1_r;
        z1_r  <= (x1_r < 0) ? 32'h80000000 : 32'h0;
        xn2_r <= x2_r < 0;
        yp2_r <= y2_r >= 0;
        zv2_r <= (x2_r == 0) && (y2_r == 0);
        cx2_r <= (x2_r < 0) ? -x2_r : x2_r;
        cy2_r <= (x2_r < 0) ? -y2_r : y2_r;
        z2_r  <= (x2_r < 0) ? 32'h80000000 : 32'h0;
        it_r  <= '0;
      end
      BK_CORD: begin
        if (cy1_r > 0) begin
          cx1_r <= cx1_r + (cy1_r >>> it_r);
          cy1_r <= cy1_r - (cx1_r >>> it_r);
          z1_r  <= z1_r + at;
        end else begin
          cx1_r <= cx1_r - (cy1_r >>> it_r);
          cy1_r <= cy1_r + (cx1_r >>> it_r);
          z1_r  <= z1_r - at;
        end
        if (cy2_r > 0) begin
          cx2_r <= cx2_r + (cy2_r >>> it_r);
          cy2_r <= cy2_r - (cx2_r >>> it_r);
          z2_r  <= z2_r + at;
        end else begin
          cx2_r <= cx2_r - (cy2_r >>> it_r);
          cy2_r <= cy2_r + (cx2_r >>> it_r);
          z2_r  <= z2_r - at;
        end
        it_r <= it_r + 5'd1;
      end
      BK_MUL: begin
        p1_r <= 48'(ang1) * PULSE_GAIN;
        p2_r <= 48'(ang2) * PULSE_GAIN;
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_joint1_pulse   <= pl1;
      out_joint2_pulse   <= pl2;
      out_reachable      <= reach_r;
      out_joint1_clamped <= f1;
      out_joint2_clamped <= f2;
    end
  end

  assign out_valid = out_valid_r;

endmodule
